// File: sv/rsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsc_pkg;

	localparam int WORD_W    = 32;
	localparam int NUM_WORDS = 8;
	localparam int CFG_W     = 64;
	localparam int ADDR_W    = 4;

	// Counter increments, used in turn for counter words 0..7.
	localparam logic [WORD_W-1:0] STEP_CONST_A = 32'h4d34d34d;
	localparam logic [WORD_W-1:0] STEP_CONST_B = 32'hd34d34d3;
	localparam logic [WORD_W-1:0] STEP_CONST_C = 32'h34d34d34;

	localparam logic [WORD_W-1:0] MASK_LO = 32'h0000ffff;
	localparam logic [WORD_W-1:0] MASK_HI = 32'hffff0000;

	// Sequencer limits: a round runs steps 0..9, key setup runs rounds 0..3.
	localparam logic [3:0] LAST_WORD_STEP   = 4'd7;
	localparam logic [3:0] FIRST_G_STEP     = 4'd2;
	localparam logic [3:0] LAST_STEP        = 4'd9;
	localparam logic [1:0] LAST_SETUP_ROUND = 2'd3;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		word_t k3;
		word_t k2;
		word_t k1;
		word_t k0;
	} rsc_key_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_COMB,
		ST_MOD,
		ST_EMIT
	} rsc_state_t;

	function automatic word_t step_const(input logic [2:0] idx);
		word_t c;
		case (idx)
			3'd0, 3'd3, 3'd6: c = STEP_CONST_A;
			3'd1, 3'd4, 3'd7: c = STEP_CONST_B;
			default:          c = STEP_CONST_C;
		endcase
		return c;
	endfunction

	function automatic word_t rot16(input word_t v);
		return {v[15:0], v[31:16]};
	endfunction

	function automatic word_t rot8(input word_t v);
		return {v[23:0], v[31:24]};
	endfunction

endpackage

`default_nettype wire

// File: sv/rsc_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Block request channel: one 16-byte block and its restart flag.
interface rsc_in_if;
	logic        valid;
	logic        ready;
	logic        restart;
	logic [63:0] data_low;
	logic [63:0] data_high;

	modport source (output valid, output restart, output data_low, output data_high,
		input ready);
	modport sink (input valid, input restart, input data_low, input data_high,
		output ready);
endinterface

// Result channel: the block XORed with the keystream.
interface rsc_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_low;
	logic [63:0] out_high;

	modport source (output valid, output out_low, output out_high, input ready);
	modport sink (input valid, input out_low, input out_high, output ready);
endinterface

`default_nettype wire

// File: sv/rabbit_stream_cipher.sv
`timescale 1ns / 1ps
`default_nettype none

// Rabbit stream cipher with a 128-bit key, one 16-byte block per request.
// The key is written through the APB-style port: key_low at byte address 0,
// key_high at byte address 8, 64-bit data, pready always high. Write it only
// while the block is idle; it takes effect at the next request with restart set.
// A request on data_ch carries restart, data_low and data_high; the result on
// result_ch is the data XORed with the next 128 bits of keystream, so the same
// block encrypts and decrypts. The first request after reset should set restart.
// Sequence: one state round runs steps 0..9 of the single shared squaring
// unit and then a combine step. A plain block runs one round and then emits
// its result; the block becomes ready again in the same cycle as that result
// turns valid. A restart block adds key load, four setup rounds and the
// counter fix-up before that round.
// data_ch.ready is high only while the sequencer is idle. The result waits in
// the output register while result_ch.ready is low; the next request may be
// taken meanwhile, and the sequencer then holds its finished result until the
// output register is free.
// Reset clears the key, state words, counters, carry and result valid, and returns the sequencer to idle.
module rabbit_stream_cipher (
	input  wire                         clk,
	input  wire                         arst_n,
	rsc_in_if.sink                      data_ch,
	rsc_out_if.source                   result_ch,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire  [rsc_pkg::ADDR_W-1:0]  paddr,
	input  wire  [rsc_pkg::CFG_W-1:0]   pwdata,
	output logic [rsc_pkg::CFG_W-1:0]   prdata,
	output logic                        pready
);
	import rsc_pkg::*;

	rsc_key_t   key;
	rsc_state_t state_q;
	rsc_state_t state_d;

	// Cipher state. Within a round the state and counter arrays rotate by one
	// word on steps 0..7, so the word being worked on always sits at index 0.
	word_t      s_q [NUM_WORDS];
	word_t      c_q [NUM_WORDS];
	logic       carry_q;
	word_t      g_q [NUM_WORDS];
	word_t      s_new [NUM_WORDS];

	logic [3:0] step_q;
	logic [1:0] round_q;
	logic       setup_q;

	logic [63:0] data_low_q;
	logic [63:0] data_high_q;
	logic [63:0] out_low_q;
	logic [63:0] out_high_q;
	logic        out_valid_q;

	logic        accept;
	logic        emit_now;
	logic        word_step;
	logic        g_step;

	logic [WORD_W:0] cnt_sum;
	word_t           g_x;
	word_t           g_res;
	word_t           ks0, ks1, ks2, ks3;

	rsc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.key     (key)
	);

	// Counter update for the word at the head, then the g-function operand.
	assign cnt_sum = {1'b0, c_q[0]} + {1'b0, step_const(step_q[2:0])}
		+ {{WORD_W{1'b0}}, carry_q};
	assign g_x = s_q[0] + cnt_sum[WORD_W-1:0];

	rsc_gunit u_gunit (
		.clk (clk),
		.x   (g_x),
		.g   (g_res)
	);

	// Next-state function from the eight collected g values.
	always_comb begin
		s_new[0] = g_q[0] + rot16(g_q[7]) + rot16(g_q[6]);
		s_new[1] = g_q[1] + rot8(g_q[0])  + g_q[7];
		s_new[2] = g_q[2] + rot16(g_q[1]) + rot16(g_q[0]);
		s_new[3] = g_q[3] + rot8(g_q[2])  + g_q[1];
		s_new[4] = g_q[4] + rot16(g_q[3]) + rot16(g_q[2]);
		s_new[5] = g_q[5] + rot8(g_q[4])  + g_q[3];
		s_new[6] = g_q[6] + rot16(g_q[5]) + rot16(g_q[4]);
		s_new[7] = g_q[7] + rot8(g_q[6])  + g_q[5];
	end

	// Keystream extraction from the state after the block's round.
	assign ks0 = s_q[0] ^ (s_q[5] >> 16) ^ (s_q[3] << 16);
	assign ks1 = s_q[2] ^ (s_q[7] >> 16) ^ (s_q[5] << 16);
	assign ks2 = s_q[4] ^ (s_q[1] >> 16) ^ (s_q[7] << 16);
	assign ks3 = s_q[6] ^ (s_q[3] >> 16) ^ (s_q[1] << 16);

	// Sequencer: next state and strobes.
	always_comb begin
		state_d       = state_q;
		data_ch.ready = 1'b0;
		emit_now      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				data_ch.ready = 1'b1;
				if (data_ch.valid) begin
					state_d = data_ch.restart ? ST_LOAD : ST_ROUND;
				end
			end
			ST_LOAD: begin
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (step_q == LAST_STEP) begin
					state_d = ST_COMB;
				end
			end
			ST_COMB: begin
				if (!setup_q) begin
					state_d = ST_EMIT;
				end else if (round_q == LAST_SETUP_ROUND) begin
					state_d = ST_MOD;
				end else begin
					state_d = ST_ROUND;
				end
			end
			ST_MOD: begin
				state_d = ST_ROUND;
			end
			ST_EMIT: begin
				if (!out_valid_q || result_ch.ready) begin
					emit_now = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept    = data_ch.valid & data_ch.ready;
	assign word_step = (state_q == ST_ROUND) && (step_q <= LAST_WORD_STEP);
	assign g_step    = (state_q == ST_ROUND) && (step_q >= FIRST_G_STEP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control counters and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			round_q     <= '0;
			setup_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= (state_q == ST_ROUND) ? step_q + 4'd1 : 4'd0;
			if (state_q == ST_LOAD) begin
				round_q <= '0;
			end else if (state_q == ST_COMB && setup_q) begin
				round_q <= round_q + 2'd1;
			end
			if (accept) begin
				setup_q <= data_ch.restart;
			end else if (state_q == ST_MOD) begin
				setup_q <= 1'b0;
			end
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// State words, counters and carry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_WORDS; j++) begin
				s_q[j] <= '0;
				c_q[j] <= '0;
			end
			carry_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					s_q[0] <= key.k0;
					s_q[2] <= key.k1;
					s_q[4] <= key.k2;
					s_q[6] <= key.k3;
					s_q[1] <= {key.k3[15:0], key.k2[31:16]};
					s_q[3] <= {key.k0[15:0], key.k3[31:16]};
					s_q[5] <= {key.k1[15:0], key.k0[31:16]};
					s_q[7] <= {key.k2[15:0], key.k1[31:16]};
					c_q[0] <= rot16(key.k2);
					c_q[2] <= rot16(key.k3);
					c_q[4] <= rot16(key.k0);
					c_q[6] <= rot16(key.k1);
					c_q[1] <= (key.k0 & MASK_HI) | (key.k1 & MASK_LO);
					c_q[3] <= (key.k1 & MASK_HI) | (key.k2 & MASK_LO);
					c_q[5] <= (key.k2 & MASK_HI) | (key.k3 & MASK_LO);
					c_q[7] <= (key.k3 & MASK_HI) | (key.k0 & MASK_LO);
					carry_q <= 1'b0;
				end
				ST_ROUND: begin
					if (word_step) begin
						for (int j = 0; j < NUM_WORDS - 1; j++) begin
							s_q[j] <= s_q[j+1];
							c_q[j] <= c_q[j+1];
						end
						s_q[NUM_WORDS-1] <= s_q[0];
						c_q[NUM_WORDS-1] <= cnt_sum[WORD_W-1:0];
						carry_q          <= cnt_sum[WORD_W];
					end
				end
				ST_COMB: begin
					for (int j = 0; j < NUM_WORDS; j++) begin
						s_q[j] <= s_new[j];
					end
				end
				ST_MOD: begin
					// Counter word j is XORed with the state word four places away.
					for (int j = 0; j < NUM_WORDS; j++) begin
						c_q[j] <= c_q[j] ^ s_q[j ^ 4];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// g values shift in as the squaring unit delivers them.
	always_ff @(posedge clk) begin
		if (g_step) begin
			for (int j = 0; j < NUM_WORDS - 1; j++) begin
				g_q[j] <= g_q[j+1];
			end
			g_q[NUM_WORDS-1] <= g_res;
		end
	end

	// Request payload and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			data_low_q  <= data_ch.data_low;
			data_high_q <= data_ch.data_high;
		end
		if (emit_now) begin
			out_low_q  <= data_low_q  ^ {ks1, ks0};
			out_high_q <= data_high_q ^ {ks3, ks2};
		end
	end

	assign result_ch.valid    = out_valid_q;
	assign result_ch.out_low  = out_low_q;
	assign result_ch.out_high = out_high_q;

	// A request with restart always starts with the key load.
	a_restart_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept && data_ch.restart |=> state_q == ST_LOAD)
		else $error("restart request did not start key load");

	// The step counter never runs past the end of a round.
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |-> step_q <= LAST_STEP)
		else $error("round step counter out of range");

	// A result is only produced once key setup has finished.
	a_emit_after_setup: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> !setup_q)
		else $error("result emitted during key setup");

	// A new result appears only out of the emit state.
	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("result valid raised outside emit");

endmodule

`default_nettype wire

// File: sv/rsc_regs.sv
`timescale 1ns / 1ps
`default_nettype none

// Key registers behind the APB-style port. Register 0 at byte 0, register 1 at byte 8.
module rsc_regs (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire  [rsc_pkg::ADDR_W-1:0]    paddr,
	input  wire  [rsc_pkg::CFG_W-1:0]     pwdata,
	output logic [rsc_pkg::CFG_W-1:0]     prdata,
	output logic                          pready,
	output rsc_pkg::rsc_key_t             key
);
	import rsc_pkg::*;

	logic [CFG_W-1:0] key_low_q;
	logic [CFG_W-1:0] key_high_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (wr_en) begin
			if (paddr[3]) begin
				key_high_q <= pwdata;
			end else begin
				key_low_q <= pwdata;
			end
		end
	end

	assign prdata = paddr[3] ? key_high_q : key_low_q;

	assign key.k0 = key_low_q[31:0];
	assign key.k1 = key_low_q[63:32];
	assign key.k2 = key_high_q[31:0];
	assign key.k3 = key_high_q[63:32];

endmodule

`default_nettype wire

// File: sv/rsc_gunit.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared g-function unit: registers the operand, squares it, and folds the
// 64-bit square into 32 bits; the square is registered before the fold.
module rsc_gunit (
	input  wire             clk,
	input  rsc_pkg::word_t  x,
	output rsc_pkg::word_t  g
);
	import rsc_pkg::*;

	word_t                 x_s1;
	logic  [2*WORD_W-1:0]  sq_s2;

	always_ff @(posedge clk) begin
		x_s1  <= x;
		sq_s2 <= {{WORD_W{1'b0}}, x_s1} * {{WORD_W{1'b0}}, x_s1};
	end

	assign g = sq_s2[2*WORD_W-1:WORD_W] ^ sq_s2[WORD_W-1:0];

endmodule

`default_nettype wire

// File: tb/sv/tb_rabbit_stream_cipher.sv
`timescale 1ns / 1ps

// Self-checking bench for the Rabbit keystream block. Requests go in through
// data_ch, results come back on result_ch, and the key is loaded through the
// APB-style register port. A predictor in this module tracks the cipher state
// request by request. Every result is checked against the oldest prediction
// still waiting.
module tb_rabbit_stream_cipher;
	import rsc_pkg::*;

	// Worst case is a key setup on every request plus both sides stalling.
	// About 815 requests stay far below this limit.
	localparam int CYCLE_LIMIT    = 400000;
	// Settle time at the end of the run, longer than a restart request takes
	// to reach its result.
	localparam int DRAIN_CYCLES   = 70;
	localparam int IDLE_PCT       = 14;
	localparam int RANDOM_PHASES  = 16;
	localparam int PHASE_BLOCKS   = 50;
	localparam int STEADY_PHASE   = 6;
	localparam int KEY_REG_STRIDE = 8;

	typedef enum int {
		KEY_LOW_REG  = 0,
		KEY_HIGH_REG = 1
	} key_reg_t;

	typedef struct packed {
		logic        restart;
		logic [63:0] data_low;
		logic [63:0] data_high;
	} block_req_t;

	typedef struct packed {
		logic [63:0] out_low;
		logic [63:0] out_high;
	} xor_block_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [CFG_W-1:0]  pwdata;
	logic [CFG_W-1:0]  prdata;
	logic              pready;

	rsc_in_if  data_ch_if ();
	rsc_out_if result_ch_if ();

	rabbit_stream_cipher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_ch   (data_ch_if),
		.result_ch (result_ch_if),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor copy of the cipher: state words, counters, counter carry and
	// the key registers as the bench last wrote them.
	word_t            ks_state [NUM_WORDS];
	word_t            ks_count [NUM_WORDS];
	logic             ks_carry;
	logic [CFG_W-1:0] key_low_q;
	logic [CFG_W-1:0] key_high_q;

	// Requests waiting for the driver, and the results predicted for the
	// requests the block has taken.
	block_req_t blocks_to_send [$];
	xor_block_t xor_due [$];
	block_req_t block_on_bus;
	xor_block_t head_block;

	// While set, neither side inserts idle cycles.
	logic        steady;
	int          n_queued;
	int          n_accepted;
	int          n_checked;
	int          n_restarts;
	int          n_key_writes;
	int          n_errors;
	int unsigned cycles;

	function automatic word_t rotl(input word_t v, input int r);
		return (v << r) | (v >> (WORD_W - r));
	endfunction

	// Rabbit g-function: square the word to 64 bits, then XOR the two halves.
	function automatic word_t square_fold(input word_t v);
		logic [2*WORD_W-1:0] sq;
		sq = {{WORD_W{1'b0}}, v} * {{WORD_W{1'b0}}, v};
		return sq[2*WORD_W-1:WORD_W] ^ sq[WORD_W-1:0];
	endfunction

	// One round of the next-state function. First the counter chain, where the
	// carry ripples through all eight words and the last carry is kept for the
	// next round. Then the eight g values, and then the state words are mixed.
	function automatic void advance_cipher();
		word_t           g [NUM_WORDS];
		word_t           incr;
		logic [WORD_W:0] sum;
		logic            carry;
		carry = ks_carry;
		for (int i = 0; i < NUM_WORDS; i++) begin
			case (i % 3)
				0: incr = STEP_CONST_A;
				1: incr = STEP_CONST_B;
				default: incr = STEP_CONST_C;
			endcase
			sum = {1'b0, ks_count[i]} + {1'b0, incr} + carry;
			ks_count[i] = sum[WORD_W-1:0];
			carry = sum[WORD_W];
		end
		ks_carry = carry;
		for (int i = 0; i < NUM_WORDS; i++)
			g[i] = square_fold(ks_state[i] + ks_count[i]);
		ks_state[0] = g[0] + rotl(g[7], 16) + rotl(g[6], 16);
		ks_state[1] = g[1] + rotl(g[0], 8) + g[7];
		ks_state[2] = g[2] + rotl(g[1], 16) + rotl(g[0], 16);
		ks_state[3] = g[3] + rotl(g[2], 8) + g[1];
		ks_state[4] = g[4] + rotl(g[3], 16) + rotl(g[2], 16);
		ks_state[5] = g[5] + rotl(g[4], 8) + g[3];
		ks_state[6] = g[6] + rotl(g[5], 16) + rotl(g[4], 16);
		ks_state[7] = g[7] + rotl(g[6], 8) + g[5];
	endfunction

	// Key setup: spread the four key words over the state and the counters,
	// run four rounds, then fold the state back into the counters.
	function automatic void load_cipher_key();
		word_t k0;
		word_t k1;
		word_t k2;
		word_t k3;
		k0 = key_low_q[31:0];
		k1 = key_low_q[63:32];
		k2 = key_high_q[31:0];
		k3 = key_high_q[63:32];
		ks_state[0] = k0;
		ks_state[2] = k1;
		ks_state[4] = k2;
		ks_state[6] = k3;
		ks_state[1] = {k3[15:0], k2[31:16]};
		ks_state[3] = {k0[15:0], k3[31:16]};
		ks_state[5] = {k1[15:0], k0[31:16]};
		ks_state[7] = {k2[15:0], k1[31:16]};
		ks_count[0] = rotl(k2, 16);
		ks_count[2] = rotl(k3, 16);
		ks_count[4] = rotl(k0, 16);
		ks_count[6] = rotl(k1, 16);
		ks_count[1] = (k0 & MASK_HI) | (k1 & MASK_LO);
		ks_count[3] = (k1 & MASK_HI) | (k2 & MASK_LO);
		ks_count[5] = (k2 & MASK_HI) | (k3 & MASK_LO);
		ks_count[7] = (k3 & MASK_HI) | (k0 & MASK_LO);
		ks_carry = 1'b0;
		for (int r = 0; r < 4; r++)
			advance_cipher();
		for (int i = 0; i < NUM_WORDS; i++)
			ks_count[(i + 4) % NUM_WORDS] ^= ks_state[i];
	endfunction

	// Expected result of one request. The keystream is extracted after the
	// state has advanced, and the same XOR serves for both directions.
	function automatic xor_block_t crypt_block(input block_req_t req);
		word_t      s0;
		word_t      s1;
		word_t      s2;
		word_t      s3;
		xor_block_t r;
		if (req.restart)
			load_cipher_key();
		advance_cipher();
		s0 = ks_state[0] ^ (ks_state[5] >> 16) ^ (ks_state[3] << 16);
		s1 = ks_state[2] ^ (ks_state[7] >> 16) ^ (ks_state[5] << 16);
		s2 = ks_state[4] ^ (ks_state[1] >> 16) ^ (ks_state[7] << 16);
		s3 = ks_state[6] ^ (ks_state[3] >> 16) ^ (ks_state[1] << 16);
		r.out_low  = req.data_low ^ {s1, s0};
		r.out_high = req.data_high ^ {s3, s2};
		return r;
	endfunction

	// Every mismatch prints one line and is counted.
	task automatic flag_mismatch(input string what);
		n_errors++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	function automatic void queue_block(input logic restart, input logic [63:0] lo,
		input logic [63:0] hi);
		block_req_t req;
		req.restart   = restart;
		req.data_low  = lo;
		req.data_high = hi;
		blocks_to_send.push_back(req);
		n_queued++;
	endfunction

	// Random data with the all-zero and all-one words mixed in now and then.
	function automatic logic [63:0] rand_data();
		logic [63:0] v;
		case ($urandom_range(15))
			0: v = '0;
			1: v = '1;
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	// APB write: a setup cycle, then an access cycle. The register takes the
	// value at the edge where psel and penable are both high. The predictor's
	// copy is updated at that same edge. The task returns on a falling edge so
	// that requests queued next do not race the driver.
	task automatic write_key_reg(input key_reg_t idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(int'(idx) * KEY_REG_STRIDE);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == KEY_LOW_REG)
			key_low_q = value;
		else
			key_high_q = value;
		n_key_writes++;
		@(negedge clk);
	endtask

	// The block counts as idle when every queued request has been taken and
	// every predicted result has come back. Sampling on the falling edge keeps
	// this check clear of the clocked processes.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (n_accepted != n_queued || xor_due.size() != 0);
	endtask

	// Request driver. When a request is taken, its result is predicted at
	// that edge. A new request goes out only when the channel is free, and on
	// about 14 of 100 chances the driver idles instead, unless steady is set.
	always @(posedge clk) begin
		if (!arst_n) begin
			data_ch_if.valid <= 1'b0;
		end else begin
			if (data_ch_if.valid && data_ch_if.ready) begin
				xor_due.push_back(crypt_block(block_on_bus));
				n_accepted++;
				if (block_on_bus.restart)
					n_restarts++;
			end
			if (!data_ch_if.valid || data_ch_if.ready) begin
				if (blocks_to_send.size() > 0 &&
					(steady || $urandom_range(99) >= IDLE_PCT)) begin
					block_on_bus = blocks_to_send.pop_front();
					data_ch_if.valid     <= 1'b1;
					data_ch_if.restart   <= block_on_bus.restart;
					data_ch_if.data_low  <= block_on_bus.data_low;
					data_ch_if.data_high <= block_on_bus.data_high;
				end else begin
					data_ch_if.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor. The receiver drops ready at random, like the driver does.
	// Each output field is checked against the oldest waiting prediction.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch_if.ready <= 1'b0;
		end else begin
			if (result_ch_if.valid && result_ch_if.ready) begin
				n_checked++;
				if (xor_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected result %h_%h",
						result_ch_if.out_high, result_ch_if.out_low));
				end else begin
					head_block = xor_due.pop_front();
					if (result_ch_if.out_low !== head_block.out_low)
						flag_mismatch($sformatf("result %0d out_low %h, expected %h",
							n_checked, result_ch_if.out_low, head_block.out_low));
					if (result_ch_if.out_high !== head_block.out_high)
						flag_mismatch($sformatf("result %0d out_high %h, expected %h",
							n_checked, result_ch_if.out_high, head_block.out_high));
				end
			end
			result_ch_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog on the total run time.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles with %0d results outstanding",
				cycles, xor_due.size());
			$display("rabbit_stream_cipher test failed");
			$finish;
		end
	end

	initial begin
		logic restart_bit;
		int   key_pick;

		// Drive every input to a known value before the first clock edge.
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		data_ch_if.valid     = 1'b0;
		data_ch_if.restart   = 1'b0;
		data_ch_if.data_low  = '0;
		data_ch_if.data_high = '0;
		result_ch_if.ready   = 1'b0;
		steady               = 1'b0;
		n_queued             = 0;
		n_accepted           = 0;
		n_checked            = 0;
		n_restarts           = 0;
		n_key_writes         = 0;
		n_errors             = 0;
		cycles               = 0;
		key_low_q            = '0;
		key_high_q           = '0;
		ks_carry             = 1'b0;
		for (int i = 0; i < NUM_WORDS; i++) begin
			ks_state[i] = '0;
			ks_count[i] = '0;
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Right after reset, requests without restart run on the all-zero
		// state and are not flagged as errors. The first key setup then uses
		// the all-zero key that reset leaves.
		queue_block(1'b0, 64'h0, 64'h0);
		queue_block(1'b0, '1, '1);
		queue_block(1'b1, 64'h0, 64'h0);
		queue_block(1'b0, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
		wait_idle();

		// All-ones key. Two restarts in a row, then plain requests.
		write_key_reg(KEY_LOW_REG, '1);
		write_key_reg(KEY_HIGH_REG, '1);
		queue_block(1'b1, '1, '1);
		queue_block(1'b1, 64'h0, 64'h0);
		queue_block(1'b0, 64'h8000_0000_0000_0001, 64'h0000_0001_8000_0000);
		queue_block(1'b0, 64'h0, '1);
		wait_idle();

		// Alternating key bits.
		write_key_reg(KEY_LOW_REG, 64'h5555_5555_5555_5555);
		write_key_reg(KEY_HIGH_REG, 64'haaaa_aaaa_aaaa_aaaa);
		queue_block(1'b1, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
		queue_block(1'b0, '1, 64'h0);
		queue_block(1'b0, 64'hffff_0000_ffff_0000, 64'h0000_ffff_0000_ffff);
		wait_idle();

		// A key written mid-stream does nothing until the next restart. The
		// plain requests here must keep using the alternating key.
		write_key_reg(KEY_LOW_REG, 64'h0123_4567_89ab_cdef);
		write_key_reg(KEY_HIGH_REG, 64'hfedc_ba98_7654_3210);
		queue_block(1'b0, 64'h0, 64'h0);
		queue_block(1'b0, '1, '1);
		queue_block(1'b1, 64'h0, 64'h0);
		queue_block(1'b0, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
		wait_idle();

		// Random phases. Each phase writes one or both key words while the
		// block is idle, then sends a stream of requests. Most phases open with
		// a restart, and the rest go on with the old key until a later restart.
		// The driver waits for every result at the end of each phase. One
		// phase runs with no idling on either side.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			steady = (p == STEADY_PHASE);
			key_pick = $urandom_range(3);
			if (key_pick != 0)
				write_key_reg(KEY_LOW_REG, {$urandom, $urandom});
			if (key_pick != 1)
				write_key_reg(KEY_HIGH_REG, {$urandom, $urandom});
			for (int n = 0; n < PHASE_BLOCKS; n++) begin
				if (n == 0)
					restart_bit = ($urandom_range(9) < 8);
				else
					restart_bit = ($urandom_range(15) == 0);
				queue_block(restart_bit, rand_data(), rand_data());
			end
			wait_idle();
		end
		steady = 1'b0;

		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d blocks, %0d with key setup, after %0d key register writes",
			n_accepted, n_restarts, n_key_writes);
		$display("checked %0d results in %0d cycles, %0d mismatches",
			n_checked, cycles, n_errors);
		if (n_errors == 0 && xor_due.size() == 0) begin
			$display("rabbit_stream_cipher test passed");
		end else begin
			$display("rabbit_stream_cipher test failed");
		end
		$finish;
	end

endmodule
